>>> rtl/core/fvn_pkg.sv
// ----------------------------------------------------------------------------
// Fractal value noise package
// Shared constants and register indexes for the terrain column generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fvn_pkg;

  localparam int OCT      = 4;
  localparam int MAX_L    = 10;
  localparam int NW       = 12;
  localparam int CW       = 10;
  localparam int XW       = NW + MAX_L;
  localparam int FRAC     = 30;
  localparam int NSTG     = 13;

  localparam int RECIP_SH = 33;
  localparam logic [23:0] RECIP = 24'd8589935;
  localparam int MODULUS  = 1000;
  localparam int HASH_MUL = 197;
  localparam int HASH_ADD = 4721;
  localparam int LAT_HI   = 1073741;
  localparam int LAT_LO   = 824;

  localparam logic [1:0] CFG_WIDTH_LOG2    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_GAIN   = 2'd1;
  localparam logic [1:0] CFG_HEIGHT_OFFSET = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/fractal_value_noise_column.sv
// ----------------------------------------------------------------------------
// Fractal value noise terrain column
// Turns a chunk number and a column into one saturated 16-bit terrain height.
// ----------------------------------------------------------------------------
// The block accepts one column per cycle while the output is not stalled and
// returns its height through the thirteen-stage pipeline that runs all
// octaves side by side. A stalled output holds the whole pipeline, and no
// transfer is lost. Configuration writes take effect at once and are meant
// to be made while no transfer is in flight.
`timescale 1ns / 1ps
`default_nettype none

module fractal_value_noise_column import fvn_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [23:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [NW-1:0]        chunk_number_i,
  input  wire logic [CW-1:0]        column_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [15:0]        terrain_height_o
);

  logic [3:0]         width_log2_q;
  logic [19:0]        height_gain_q;
  logic signed [23:0] height_offset_q;

  logic [NSTG-1:0] vld_q;
  logic            en;

  logic [OCT-1:0][1:0][XW-1:0] x1_d, x1_q, x2_q;
  logic [OCT-1:0][CW:0]        m1_d, m1_q, m2_q;
  logic [OCT-1:0][3:0]         e1_d, e1_q, e2_q, e3_q;
  logic [OCT-1:0]              a1_d, a1_q, a2_q, a3_q, a4_q, a5_q, a6_q, a7_q, a8_q, a9_q;
  logic [OCT-1:0][1:0][12:0]   q2_d;
  logic [OCT-1:0][1:0][12:0]   q2_q;
  logic [OCT-1:0][20:0]        msq2_d, msq2_q;
  logic [OCT-1:0][1:0][17:0]   t3_d, t3_q, t4_q;
  logic [OCT-1:0][30:0]        num3_d, num3_q;
  logic [OCT-1:0][1:0][7:0]    d4_d, d4_q;
  logic [OCT-1:0][30:0]        s4_d, s4_q, s5_q, s6_q, s7_q, s8_q;
  logic [OCT-1:0][1:0][9:0]    h5_d, h5_q;
  logic [OCT-1:0][1:0][30:0]   hi6_d, hi6_q, hi7_q;
  logic [OCT-1:0][1:0][19:0]   b6_d, b6_q;
  logic [OCT-1:0][1:0][9:0]    c7_d, c7_q;
  logic [OCT-1:0][30:0]        v8_d, v8_q, v9_q;
  logic signed [31:0]          d8_d [OCT];
  logic signed [31:0]          d8_q [OCT];
  logic signed [63:0]          p9_d [OCT];
  logic signed [63:0]          p9_q [OCT];
  logic [31:0]                 sum10_d, sum10_q;
  logic [51:0]                 prod11_d, prod11_q;
  logic signed [55:0]          acc12_d, acc12_q;
  logic signed [15:0]          out13_d;

  logic [3:0]    lim_l;
  logic [CW-1:0] col_m;
  logic [XW-1:0] nw;

  assign en         = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[NSTG-1];

  always_comb begin
    logic [3:0]    e;
    logic [CW-1:0] lowm;
    logic [XW-1:0] base;
    lim_l = (width_log2_q > 4'(MAX_L)) ? 4'(MAX_L) : width_log2_q;
    col_m = column_i & CW'((32'd1 << lim_l) - 32'd1);
    nw    = XW'(chunk_number_i) << lim_l;
    for (int o = 0; o < OCT; o++) begin
      e        = lim_l - 4'(o);
      lowm     = CW'((32'd1 << e) - 32'd1);
      base     = XW'(col_m & ~lowm);
      a1_d[o]  = (4'(o) <= lim_l);
      e1_d[o]  = e;
      m1_d[o]  = (CW + 1)'(col_m & lowm) + (CW + 1)'(1);
      if (chunk_number_i == '0 && base == '0) begin
        x1_d[o][0] = (XW'(256) << lim_l) - XW'(1);
      end else begin
        x1_d[o][0] = nw + base - XW'(1);
      end
      x1_d[o][1] = nw + base + XW'((32'd1 << e) - 32'd1);
    end
  end

  always_comb begin
    logic [12:0] ftri;
    logic [32:0] num;
    logic [9:0]  r;
    logic [4:0]  sh;
    logic signed [31:0] y;
    sum10_d = '0;
    for (int o = 0; o < OCT; o++) begin
      msq2_d[o] = 21'(m1_q[o]) * 21'(m1_q[o]);
      ftri      = 13'(13'd3 * (13'd1 << e2_q[o])) - 13'(13'd2 * 13'(m2_q[o]));
      num       = 33'(msq2_q[o]) * 33'(ftri);
      num3_d[o] = num[30:0];
      sh        = 5'(6'd30 - 6'(6'd3 * 6'(e3_q[o])));
      s4_d[o]   = 31'(num3_q[o] << sh);
      for (int s = 0; s < 2; s++) begin
        q2_d[o][s]  = 13'((46'(x1_q[o][s]) * 46'(RECIP)) >> RECIP_SH);
        r           = 10'(x2_q[o][s] - XW'(q2_q[o][s]) * XW'(MODULUS));
        t3_d[o][s]  = 18'(r) * 18'(HASH_MUL) + 18'(HASH_ADD);
        d4_d[o][s]  = 8'((42'(t3_q[o][s]) * 42'(RECIP)) >> RECIP_SH);
        h5_d[o][s]  = 10'(t4_q[o][s] - 18'(d4_q[o][s]) * 18'(MODULUS) + 18'd1);
        hi6_d[o][s] = 31'(h5_q[o][s]) * 31'(LAT_HI);
        b6_d[o][s]  = 20'(h5_q[o][s]) * 20'(LAT_LO) + 20'd500;
        c7_d[o][s]  = 10'((44'(b6_q[o][s]) * 44'(RECIP)) >> RECIP_SH);
      end
      v8_d[o] = hi7_q[o][0] + 31'(c7_q[o][0]);
      d8_d[o] = $signed({1'b0, hi7_q[o][1] + 31'(c7_q[o][1])}) - $signed({1'b0, v8_d[o]});
      p9_d[o] = 64'(d8_q[o]) * 64'($signed({1'b0, s8_q[o]}));
      y       = $signed({1'b0, v9_q[o]}) + 32'(p9_q[o] >>> FRAC);
      if (a9_q[o]) begin
        sum10_d = sum10_d + (32'(y) >> (2 * o));
      end
    end
  end

  always_comb begin
    logic signed [55:0] rnd;
    logic signed [17:0] qv;
    prod11_d = 52'(sum10_q) * 52'(height_gain_q);
    acc12_d  = $signed({4'b0, prod11_q}) + (56'(height_offset_q) <<< FRAC)
             + (56'sd1 <<< (FRAC + 7));
    rnd      = acc12_q[55] ? acc12_q + ((56'sd1 <<< (FRAC + 8)) - 56'sd1) : acc12_q;
    qv       = 18'(rnd >>> (FRAC + 8));
    if (qv > 18'sd32767) begin
      out13_d = 16'sd32767;
    end else if (qv < -18'sd32768) begin
      out13_d = -16'sd32768;
    end else begin
      out13_d = 16'(qv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q    <= 4'd6;
      height_gain_q   <= 20'd25600;
      height_offset_q <= '0;
      vld_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WIDTH_LOG2:    width_log2_q    <= cfg_data_i[3:0];
          CFG_HEIGHT_GAIN:   height_gain_q   <= cfg_data_i[19:0];
          CFG_HEIGHT_OFFSET: height_offset_q <= cfg_data_i;
          default:           ;
        endcase
      end
      if (en) begin
        vld_q <= {vld_q[NSTG-2:0], in_valid_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= x1_d;   m1_q  <= m1_d;   e1_q  <= e1_d;   a1_q <= a1_d;
      x2_q   <= x1_q;   q2_q  <= q2_d;   msq2_q <= msq2_d;
      m2_q   <= m1_q;   e2_q  <= e1_q;   a2_q  <= a1_q;
      t3_q   <= t3_d;   num3_q <= num3_d; e3_q <= e2_q;   a3_q <= a2_q;
      t4_q   <= t3_q;   d4_q  <= d4_d;   s4_q  <= s4_d;   a4_q <= a3_q;
      h5_q   <= h5_d;   s5_q  <= s4_q;   a5_q  <= a4_q;
      hi6_q  <= hi6_d;  b6_q  <= b6_d;   s6_q  <= s5_q;   a6_q <= a5_q;
      hi7_q  <= hi6_q;  c7_q  <= c7_d;   s7_q  <= s6_q;   a7_q <= a6_q;
      v8_q   <= v8_d;   d8_q  <= d8_d;   s8_q  <= s7_q;   a8_q <= a7_q;
      v9_q   <= v8_q;   p9_q  <= p9_d;   a9_q  <= a8_q;
      sum10_q  <= sum10_d;
      prod11_q <= prod11_d;
      acc12_q  <= acc12_d;
      terrain_height_o <= out13_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fvn_checker.sv
// ----------------------------------------------------------------------------
// Fractal value noise port checker
// Watches the top level's handshakes over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fvn_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] terrain_height_o
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(terrain_height_o))
    else $error("output transfer dropped or changed while stalled");

  // The input side only waits while a result is held back.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without an output stall");

  // A taken result frees the pipeline in the same cycle.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input not ready during an output transfer");

endmodule

bind fractal_value_noise_column fvn_checker u_fvn_checker (.*);

`default_nettype wire
